/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RNF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, disabled while reset is low
`define RNF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

/* rtl/core/rnf_pkg.sv */
// shared types, constants and helpers of the radix number formatter
package rnf_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int MAX_DIGITS = 32;

    localparam logic [7:0] MINUS_SYMBOL = 8'h2D;
    localparam logic [7:0] PLUS_SYMBOL  = 8'h2B;

    localparam logic [4:0]  RADIX_RESET    = 5'd10;
    localparam logic [63:0] ALPHA_LO_RESET = 64'h3736_3534_3332_3130;
    localparam logic [63:0] ALPHA_HI_RESET = 64'h0000_0000_0000_3938;

    localparam logic [1:0] CFG_RADIX    = 2'd0;
    localparam logic [1:0] CFG_ALPHA_LO = 2'd1;
    localparam logic [1:0] CFG_ALPHA_HI = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic load;
        logic check_step;
        logic conv_step;
        logic emit_sign;
        logic emit_digit;
        logic emit_error;
    } t_cmd;

    typedef struct packed {
        logic check_fail;
        logic check_done;
        logic conv_done;
        logic negative;
        logic digit_last;
    } t_status;

    function automatic logic [7:0] sym_at(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [3:0] idx);
        logic [63:0] word;
        word = idx[3] ? hi : lo;
        word = word >> {idx[2:0], 3'b000};
        return word[7:0];
    endfunction

endpackage

/* rtl/core/rnf_ctrl.sv */
// controller state machine of the radix number formatter
module rnf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  rnf_pkg::t_status i_status,
    output rnf_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    rnf_pkg::t_state r_state;
    rnf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rnf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            rnf_pkg::ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = rnf_pkg::ST_CHECK;
                end
            end
            rnf_pkg::ST_CHECK: begin
                o_cmd.check_step = 1'b1;
                if (i_status.check_fail) begin
                    o_cmd.emit_error = 1'b1;
                    n_state          = rnf_pkg::ST_IDLE;
                end else if (i_status.check_done) begin
                    n_state = rnf_pkg::ST_CONVERT;
                end
            end
            rnf_pkg::ST_CONVERT: begin
                o_cmd.conv_step = 1'b1;
                if (i_status.conv_done) begin
                    n_state = i_status.negative ? rnf_pkg::ST_SIGN : rnf_pkg::ST_DIGITS;
                end
            end
            rnf_pkg::ST_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                n_state         = rnf_pkg::ST_DIGITS;
            end
            rnf_pkg::ST_DIGITS: begin
                o_cmd.emit_digit = 1'b1;
                if (i_status.digit_last) begin
                    n_state = rnf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rnf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/rnf_dp.sv */
// datapath: configuration, alphabet check, bit-serial conversion, symbol output
module rnf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    input  logic signed [31:0] i_value,
    input  rnf_pkg::t_cmd      i_cmd,
    output rnf_pkg::t_status   o_status,
    output logic               o_valid,
    output logic [7:0]         o_symbol,
    output logic               o_last,
    output logic               o_bad_alphabet
);

    localparam logic [4:0] MAX_RADIX_W = 5'(rnf_pkg::MAX_RADIX);

    logic [4:0]  r_radix;
    logic [63:0] r_alo;
    logic [63:0] r_ahi;
    logic [31:0] r_mag, n_mag;
    logic        r_neg, n_neg;
    logic [4:0]  r_bit, n_bit;
    logic [3:0]  r_ci, n_ci;
    logic [5:0]  r_count, n_count;
    logic [3:0]  r_digits [rnf_pkg::MAX_DIGITS];
    logic [3:0]  n_digits [rnf_pkg::MAX_DIGITS];
    logic        r_valid, n_valid;
    logic [7:0]  r_symbol, n_symbol;
    logic        r_last, n_last;
    logic        r_bad, n_bad;

    // alphabet check, one symbol a cycle
    logic [7:0] sym_i;
    logic       radix_bad;
    logic       sym_bad;
    logic       dup;

    always_comb begin
        sym_i     = rnf_pkg::sym_at(r_alo, r_ahi, r_ci);
        radix_bad = (r_radix < 5'd2) || (r_radix > MAX_RADIX_W);
        sym_bad   = (sym_i == 8'h00) || (sym_i == rnf_pkg::PLUS_SYMBOL)
                    || (sym_i == rnf_pkg::MINUS_SYMBOL);
        dup = 1'b0;
        for (int j = 0; j < rnf_pkg::MAX_RADIX; j++) begin
            if ((5'(j) > {1'b0, r_ci}) && (5'(j) < r_radix)
                && (rnf_pkg::sym_at(r_alo, r_ahi, 4'(j)) == sym_i)) begin
                dup = 1'b1;
            end
        end
    end

    // doubling of the digit row with carry vector from one wide add
    logic [31:0] gen;
    logic [31:0] prop;
    logic [32:0] add_a;
    logic [32:0] add_b;
    logic [32:0] add_sum;
    logic [32:0] carry_in;
    logic [3:0]  dbl_digits [rnf_pkg::MAX_DIGITS];

    always_comb begin
        for (int i = 0; i < rnf_pkg::MAX_DIGITS; i++) begin
            gen[i]  = {r_digits[i], 1'b0} >= r_radix;
            prop[i] = {r_digits[i], 1'b1} == r_radix;
        end
        add_a    = {1'b0, gen | prop};
        add_b    = {1'b0, gen};
        add_sum  = add_a + add_b + {32'd0, r_mag[31]};
        carry_in = add_sum ^ add_a ^ add_b;
        for (int i = 0; i < rnf_pkg::MAX_DIGITS; i++) begin
            logic [4:0] s;
            s = {r_digits[i], carry_in[i]};
            if (s >= r_radix) begin
                s = s - r_radix;
            end
            dbl_digits[i] = s[3:0];
        end
    end

    logic [5:0] emit_pos;
    logic [3:0] emit_digit;

    assign emit_pos   = r_count - 6'd1;
    assign emit_digit = r_digits[emit_pos[4:0]];

    always_comb begin
        o_status.check_fail = radix_bad || sym_bad || dup;
        o_status.check_done = ({1'b0, r_ci} == (r_radix - 5'd1));
        o_status.conv_done  = (r_bit == 5'd31);
        o_status.negative   = r_neg;
        o_status.digit_last = (r_count == 6'd1);
    end

    always_comb begin
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_bit    = r_bit;
        n_ci     = r_ci;
        n_count  = r_count;
        n_digits = r_digits;
        n_valid  = 1'b0;
        n_symbol = r_symbol;
        n_last   = r_last;
        n_bad    = r_bad;
        if (i_cmd.load) begin
            n_neg   = i_value[31];
            n_mag   = i_value[31] ? (32'd0 - 32'(i_value)) : 32'(i_value);
            n_bit   = '0;
            n_ci    = '0;
            n_count = 6'd1;
            for (int i = 0; i < rnf_pkg::MAX_DIGITS; i++) begin
                n_digits[i] = '0;
            end
        end
        if (i_cmd.check_step) begin
            n_ci = r_ci + 4'd1;
        end
        if (i_cmd.conv_step) begin
            n_mag    = {r_mag[30:0], 1'b0};
            n_bit    = r_bit + 5'd1;
            n_digits = dbl_digits;
            if (carry_in[r_count]) begin
                n_count = r_count + 6'd1;
            end
        end
        if (i_cmd.emit_error) begin
            n_valid  = 1'b1;
            n_symbol = 8'h00;
            n_last   = 1'b1;
            n_bad    = 1'b1;
        end
        if (i_cmd.emit_sign) begin
            n_valid  = 1'b1;
            n_symbol = rnf_pkg::MINUS_SYMBOL;
            n_last   = 1'b0;
            n_bad    = 1'b0;
        end
        if (i_cmd.emit_digit) begin
            n_valid  = 1'b1;
            n_symbol = rnf_pkg::sym_at(r_alo, r_ahi, emit_digit);
            n_last   = (r_count == 6'd1);
            n_bad    = 1'b0;
            n_count  = r_count - 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= rnf_pkg::RADIX_RESET;
            r_alo   <= rnf_pkg::ALPHA_LO_RESET;
            r_ahi   <= rnf_pkg::ALPHA_HI_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rnf_pkg::CFG_RADIX:    r_radix <= i_cfg_data[4:0];
                rnf_pkg::CFG_ALPHA_LO: r_alo   <= i_cfg_data;
                rnf_pkg::CFG_ALPHA_HI: r_ahi   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_bit   <= '0;
            r_ci    <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_bit   <= n_bit;
            r_ci    <= n_ci;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_symbol <= n_symbol;
        r_last   <= n_last;
        r_bad    <= n_bad;
    end

    assign o_valid        = r_valid;
    assign o_symbol       = r_symbol;
    assign o_last         = r_last;
    assign o_bad_alphabet = r_bad;

endmodule

/* rtl/core/radix_number_formatter.sv */
// top level of the radix number formatter
// A value is taken at a rising edge with i_start high and o_busy low. The block first checks
// the alphabet, one symbol per cycle (each of the radix symbols in turn; a bad symbol ends the
// check early, and an out-of-range radix ends it at the first symbol), then converts the
// magnitude bit-serially, one magnitude bit per cycle through all 32 bits, and then puts out
// the minus sign, if any, and the digits, most significant first, one beat per cycle on
// o_valid. A negative value at radix 2 gives the most beats: the sign and 32 digits. A bad
// alphabet gives one beat with o_bad_alphabet and o_last set right after the check.
// Beats cannot be held off: each one is on the ports for exactly one cycle and must be taken
// then. o_busy falls as the last beat shows, and the next value may be started in that cycle.
// Configuration is to be written on i_cfg_we only while the block is not busy; the block
// itself does not enforce this.
module radix_number_formatter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_value,
    output logic               o_busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data,
    output logic               o_valid,
    output logic [7:0]         o_symbol,
    output logic               o_last,
    output logic               o_bad_alphabet
);

    rnf_pkg::t_cmd    cmd;
    rnf_pkg::t_status status;

    rnf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    rnf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_last         (o_last),
        .o_bad_alphabet (o_bad_alphabet)
    );

endmodule

/* rtl/core/rnf_checker.sv */
// port-level checker of the radix number formatter and its bind
`include "assert_macros.svh"

module rnf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_busy,
    input logic       i_valid,
    input logic [7:0] i_symbol,
    input logic       i_last,
    input logic       i_bad_alphabet
);

    // a run of beats has no gaps
    `RNF_ASSERT_NEXT(a_run_gapless, i_clk, i_rst_n, i_valid && !i_last, i_valid)
    // an error beat is a single zero symbol
    `RNF_ASSERT_NOW(a_error_beat, i_clk, i_rst_n, i_valid && i_bad_alphabet, i_last && (i_symbol == 8'h00))
    // a started value makes the block busy
    `RNF_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start && !i_busy, i_busy)
    // busy only drops with the final beat
    `RNF_ASSERT_NOW(a_idle_last, i_clk, i_rst_n, i_valid && !i_busy, i_last)

endmodule

bind radix_number_formatter rnf_checker u_rnf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .i_busy         (o_busy),
    .i_valid        (o_valid),
    .i_symbol       (o_symbol),
    .i_last         (o_last),
    .i_bad_alphabet (o_bad_alphabet)
);
